>>> rtl/tcw_pkg.sv
// ============================================================================
// tcw_pkg: shared definitions for the text console cell writer
// Screen geometry, character codes, command kinds, the sequencer states,
// the screen store request bundle and small helper functions.
// ============================================================================
package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int NCELLS  = COLUMNS * ROWS;

    // Field widths of the item ports.
    localparam int KIND_W = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int REQ_W  = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int OFF_W  = 11;

    // Screen store geometry.
    localparam int CELL_W = CHAR_W + ATTR_W;
    localparam int ADDR_W = $clog2(NCELLS);

    localparam logic [ADDR_W-1:0] LAST_MOVE = ADDR_W'(NCELLS - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(NCELLS - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

    // Character codes with a meaning of their own.
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Attribute used by the clearing pass after reset.
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

    // Tab stops sit on multiples of four.
    localparam logic [COL_W:0] TAB_STEP = (COL_W+1)'(4);
    localparam logic [COL_W:0] TAB_MASK = ~((COL_W+1)'(3));

    typedef enum logic [KIND_W-1:0] {
        K_PUT   = 2'd0,
        K_SET   = 2'd1,
        K_CLEAR = 2'd2,
        K_READ  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCROLL_RD,
        S_SCROLL_WR,
        S_BLANK,
        S_RESULT
    } t_state;

    // One write and one read request to the screen store per cycle.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    function automatic logic [CELL_W-1:0] blank_cell(input logic [ATTR_W-1:0] attr);
        return {attr, CH_SPACE};
    endfunction

    function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        return ADDR_W'(int'(row) * COLUMNS + int'(col));
    endfunction

    function automatic logic [OFF_W-1:0] cursor_offset(input logic [ROW_W-1:0] row,
                                                       input logic [COL_W-1:0] col);
        return OFF_W'(int'(row) * COLUMNS + int'(col));
    endfunction

    function automatic logic [COL_W-1:0] clamp_col(input logic signed [REQ_W-1:0] v);
        if (v < 0) begin
            return '0;
        end else if (int'(v) >= COLUMNS) begin
            return COL_W'(COLUMNS - 1);
        end
        return COL_W'(v);
    endfunction

    function automatic logic [ROW_W-1:0] clamp_row(input logic signed [REQ_W-1:0] v);
        if (v < 0) begin
            return '0;
        end else if (int'(v) >= ROWS) begin
            return ROW_W'(ROWS - 1);
        end
        return ROW_W'(v);
    endfunction

endpackage

>>> rtl/tcw_screen_ram.sv
// ============================================================================
// tcw_screen_ram: character cell store
// One write port and one read port with registered read data.
// ============================================================================
module tcw_screen_ram (
    input  logic                      i_clk,
    input  tcw_pkg::t_ram_req         i_req,
    output logic [tcw_pkg::CELL_W-1:0] o_rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] r_mem [NCELLS];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read data holds until the next read request.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/text_console_cell_writer.sv
// ============================================================================
// text_console_cell_writer: text console engine with a character cell store
// Keeps a screen of character cells and a cursor, and executes one command
// item at a time: put char, set cursor, clear screen and read cell.
// ============================================================================
//
//  Channel   Direction  Handshake            Content
//  input     in         i_valid / o_stall    kind, char_code, col/row request
//  result    out        o_valid / i_stall    cursor col/row/offset, cell data
//  config    in         i_cfg_wr_en          fill attribute byte
//
// Put char, set cursor and read cell pass from S_EXEC through S_RESULT to
// the result register, which may wait on i_stall; the next item is only
// accepted once the sequencer is back in S_IDLE. A put char that scrolls
// walks the store through its read and write ports: each moved cell is read
// in S_SCROLL_RD and written in S_SCROLL_WR, then the bottom row is blanked.
// Clear screen writes one cell per cycle. After reset a clearing pass fills
// the store with blank cells of attribute 7; no item is accepted during it,
// but configuration writes are taken. o_stall is high whenever the
// sequencer is not idle.
// ============================================================================
module text_console_cell_writer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       i_cfg_wr_en,
    input  logic [tcw_pkg::ATTR_W-1:0] i_cfg_wr_data,

    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [tcw_pkg::KIND_W-1:0] i_kind,
    input  logic [tcw_pkg::CHAR_W-1:0] i_char_code,
    input  logic signed [tcw_pkg::REQ_W-1:0] i_col_request,
    input  logic signed [tcw_pkg::REQ_W-1:0] i_row_request,

    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [tcw_pkg::COL_W-1:0]  o_cursor_col_now,
    output logic [tcw_pkg::ROW_W-1:0]  o_cursor_row_now,
    output logic [tcw_pkg::OFF_W-1:0]  o_cursor_offset,
    output logic [tcw_pkg::CHAR_W-1:0] o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0] o_cell_attr
);
    import tcw_pkg::*;

    // Sequencer and control state.
    t_state            r_state, n_state;
    logic              r_init;      // the clearing pass after reset is running
    logic [ADDR_W-1:0] r_ptr;       // cell pointer for scroll and blank sweeps
    logic [ATTR_W-1:0] r_fill;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic              r_out_valid;

    // Latched command item.
    t_kind                    r_kind;
    logic [CHAR_W-1:0]        r_code;
    logic signed [REQ_W-1:0]  r_colq;
    logic signed [REQ_W-1:0]  r_rowq;

    // Result register.
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic [OFF_W-1:0]  r_out_off;
    logic [CHAR_W-1:0] r_out_char;
    logic [ATTR_W-1:0] r_out_attr;

    t_ram_req          ram_req;
    logic [CELL_W-1:0] ram_rdata;

    // Put char outcome, worked out from the latched item and the cursor.
    logic [COL_W:0]    pc_col_w;
    logic [ROW_W:0]    pc_row_w;
    logic [COL_W-1:0]  pc_wcol;
    logic              pc_we;
    logic [CELL_W-1:0] pc_wdata;
    logic              pc_scroll;

    logic              load_out;
    logic              blank_done;
    logic [ATTR_W-1:0] blank_attr;

    tcw_screen_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign load_out   = !r_out_valid || !i_stall;
    assign blank_done = (r_ptr == LAST_CELL);
    assign blank_attr = r_init ? RESET_ATTR : r_fill;

    // Put char: newline, backspace, tab or any other byte, then the wrap
    // at the right edge and the scroll check at the bottom.
    always_comb begin
        pc_col_w = {1'b0, r_col};
        pc_row_w = {1'b0, r_row};
        pc_wcol  = r_col;
        pc_we    = 1'b0;
        pc_wdata = {r_fill, r_code};
        case (r_code)
            CH_NL: begin
                pc_col_w = '0;
                pc_row_w = pc_row_w + 1'b1;
            end
            CH_BS: begin
                // Backspace at the first column leaves everything alone.
                if (r_col != '0) begin
                    pc_col_w = pc_col_w - 1'b1;
                    pc_wcol  = r_col - 1'b1;
                    pc_we    = 1'b1;
                    pc_wdata = blank_cell(r_fill);
                end
            end
            CH_TAB: begin
                pc_col_w = (pc_col_w + TAB_STEP) & TAB_MASK;
            end
            default: begin
                pc_we    = 1'b1;
                pc_col_w = pc_col_w + 1'b1;
            end
        endcase
        if (pc_col_w >= (COL_W+1)'(COLUMNS)) begin
            pc_col_w = '0;
            pc_row_w = pc_row_w + 1'b1;
        end
        pc_scroll = (pc_row_w >= (ROW_W+1)'(ROWS));
        if (pc_scroll) begin
            pc_row_w = (ROW_W+1)'(ROWS - 1);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_kind)
                    K_PUT:         n_state = pc_scroll ? S_SCROLL_RD : S_RESULT;
                    K_CLEAR:       n_state = S_BLANK;
                    K_SET, K_READ: n_state = S_RESULT;
                endcase
            end
            S_SCROLL_RD: begin
                n_state = S_SCROLL_WR;
            end
            S_SCROLL_WR: begin
                if (r_ptr == LAST_MOVE) begin
                    n_state = S_BLANK;
                end else begin
                    n_state = S_SCROLL_RD;
                end
            end
            S_BLANK: begin
                if (blank_done) begin
                    n_state = r_init ? S_IDLE : S_RESULT;
                end
            end
            S_RESULT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // Store requests and the input stall.
    always_comb begin
        ram_req = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
            end
            S_EXEC: begin
                if (r_kind == K_PUT) begin
                    ram_req.we    = pc_we;
                    ram_req.waddr = cell_index(r_row, pc_wcol);
                    ram_req.wdata = pc_wdata;
                end else if (r_kind == K_READ) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = cell_index(clamp_row(r_rowq), clamp_col(r_colq));
                end
            end
            S_SCROLL_RD: begin
                // Fetch the cell one row below the one about to be written.
                ram_req.re    = 1'b1;
                ram_req.raddr = r_ptr + ROW_STEP;
            end
            S_SCROLL_WR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_ptr;
                ram_req.wdata = ram_rdata;
            end
            S_BLANK: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_ptr;
                ram_req.wdata = blank_cell(blank_attr);
            end
            S_RESULT: begin
                o_stall = 1'b1;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BLANK;
            r_init      <= 1'b1;
            r_ptr       <= '0;
            r_fill      <= RESET_ATTR;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_fill <= i_cfg_wr_data;
            end
            if (r_state == S_RESULT && load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_EXEC: begin
                    r_ptr <= '0;
                    unique case (r_kind)
                        K_PUT: begin
                            r_col <= pc_col_w[COL_W-1:0];
                            r_row <= pc_row_w[ROW_W-1:0];
                        end
                        K_SET: begin
                            r_col <= clamp_col(r_colq);
                            r_row <= clamp_row(r_rowq);
                        end
                        K_CLEAR: begin
                            r_col <= '0;
                            r_row <= '0;
                        end
                        K_READ: begin
                            r_col <= r_col;
                        end
                    endcase
                end
                S_SCROLL_WR: begin
                    r_ptr <= r_ptr + 1'b1;
                end
                S_BLANK: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (blank_done) begin
                        r_init <= 1'b0;
                    end
                end
                default: begin
                    r_ptr <= r_ptr;
                end
            endcase
        end
    end

    // Item and result payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_kind <= t_kind'(i_kind);
            r_code <= i_char_code;
            r_colq <= i_col_request;
            r_rowq <= i_row_request;
        end
        if (r_state == S_RESULT && load_out) begin
            r_out_col <= r_col;
            r_out_row <= r_row;
            r_out_off <= cursor_offset(r_row, r_col);
            if (r_kind == K_READ) begin
                r_out_char <= ram_rdata[CHAR_W-1:0];
                r_out_attr <= ram_rdata[CELL_W-1:CHAR_W];
            end else begin
                r_out_char <= '0;
                r_out_attr <= '0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_cursor_col_now = r_out_col;
    assign o_cursor_row_now = r_out_row;
    assign o_cursor_offset  = r_out_off;
    assign o_cell_char      = r_out_char;
    assign o_cell_attr      = r_out_attr;

endmodule
